### src/iprt_pkg.sv
// Shared types, codes and constants of the IPv4 forwarding route table.
package iprt_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned PEER_W  = 16;
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned TOTAL_W = 7;

  localparam int unsigned IN_TDATA_W  = 184;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [1:0] REG_MY_ADDR    = 2'd0;
  localparam logic [1:0] REG_LOCAL_PORT = 2'd1;

  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  IP_VERSION_6   = 4'd6;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam logic [15:0] MIN_PKT_LEN    = 16'd20;
  localparam logic [7:0]  TTL_ADVERT     = 8'd1;
  localparam logic [7:0]  MCAST_FIRST    = 8'd224;
  localparam logic [7:0]  MCAST_LAST     = 8'd239;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;
  localparam logic signed [PRIO_W-1:0] PKT_PRIO = -32'sd1;

  typedef enum logic [2:0] {
    ACT_MALFORMED,
    ACT_OWN_DROP,
    ACT_TTL_DROP,
    ACT_FLOOD,
    ACT_MISS,
    ACT_UNICAST,
    ACT_IPV6,
    ACT_ADVERT
  } action_e;

  typedef enum logic [1:0] {
    LS_SAME,
    LS_ADDED,
    LS_REPLACED,
    LS_FULL
  } learn_e;

  typedef struct packed {
    logic                     valid;
    logic                     learn_en;
    logic                     learn_done;
    learn_e                   ls;
    logic [ADDR_W-1:0]        learn_addr;
    logic [PORT_W-1:0]        learn_port;
    logic [PEER_W-1:0]        learn_peer;
    logic signed [PRIO_W-1:0] learn_prio;
    logic                     lookup_en;
    logic [ADDR_W-1:0]        dst_addr;
    logic                     hit;
    logic [PORT_W-1:0]        hit_port;
    logic [PEER_W-1:0]        hit_peer;
    action_e                  base_action;
    logic [PORT_W-1:0]        base_port;
  } token_t;

endpackage

### src/iprt_decode.sv
// Header checks and action decision that build the token entering the cell chain.
module iprt_decode (
  input  logic                              valid_i,
  input  logic [iprt_pkg::IN_TDATA_W-1:0]   tdata_i,
  input  logic                              tuser_i,
  input  logic [iprt_pkg::ADDR_W-1:0]       my_addr_i,
  input  logic [iprt_pkg::PORT_W-1:0]       local_port_i,
  output iprt_pkg::token_t                  tok_o
);

  logic [3:0]                        version;
  logic [3:0]                        hdr_words;
  logic [7:0]                        ttl;
  logic [15:0]                       pkt_len;
  logic [iprt_pkg::ADDR_W-1:0]       src_addr;
  logic [iprt_pkg::ADDR_W-1:0]       dst_addr;
  logic [iprt_pkg::PORT_W-1:0]       ingress_port;
  logic [iprt_pkg::PEER_W-1:0]       from_endpoint;
  logic [iprt_pkg::ADDR_W-1:0]       advert_addr;
  logic signed [iprt_pkg::PRIO_W-1:0] advert_prio;
  logic [7:0]                        dst_top;
  logic                              is_flood;

  assign version       = tdata_i[3:0];
  assign hdr_words     = tdata_i[7:4];
  assign ttl           = tdata_i[15:8];
  assign pkt_len       = tdata_i[31:16];
  assign src_addr      = tdata_i[63:32];
  assign dst_addr      = tdata_i[95:64];
  assign ingress_port  = tdata_i[97:96];
  assign from_endpoint = tdata_i[113:98];
  assign advert_addr   = tdata_i[145:114];
  assign advert_prio   = $signed(tdata_i[177:146]);

  assign dst_top  = dst_addr[31:24];
  assign is_flood = (dst_addr == iprt_pkg::BCAST_ADDR) ||
                    ((dst_top >= iprt_pkg::MCAST_FIRST) && (dst_top <= iprt_pkg::MCAST_LAST));

  always_comb begin
    tok_o             = '0;
    tok_o.valid       = valid_i;
    tok_o.ls          = iprt_pkg::LS_SAME;
    tok_o.learn_port  = ingress_port;
    tok_o.learn_peer  = from_endpoint;
    tok_o.dst_addr    = dst_addr;
    tok_o.hit         = 1'b0;
    tok_o.base_action = iprt_pkg::ACT_MALFORMED;
    if (tuser_i) begin
      tok_o.learn_en    = (advert_addr != my_addr_i);
      tok_o.learn_addr  = advert_addr;
      tok_o.learn_prio  = advert_prio;
      tok_o.base_action = iprt_pkg::ACT_ADVERT;
    end else if ((pkt_len < iprt_pkg::MIN_PKT_LEN) ||
                 ((version != iprt_pkg::IP_VERSION_4) && (version != iprt_pkg::IP_VERSION_6))) begin
      tok_o.base_action = iprt_pkg::ACT_MALFORMED;
    end else if (version == iprt_pkg::IP_VERSION_6) begin
      tok_o.base_action = iprt_pkg::ACT_IPV6;
    end else if (hdr_words < iprt_pkg::MIN_HDR_WORDS) begin
      tok_o.base_action = iprt_pkg::ACT_MALFORMED;
    end else if ((src_addr == my_addr_i) && (ingress_port != local_port_i)) begin
      tok_o.base_action = iprt_pkg::ACT_OWN_DROP;
    end else begin
      tok_o.learn_en   = (src_addr != my_addr_i);
      tok_o.learn_addr = src_addr;
      tok_o.learn_prio = iprt_pkg::PKT_PRIO;
      if (ttl == iprt_pkg::TTL_ADVERT) begin
        tok_o.base_action = iprt_pkg::ACT_TTL_DROP;
      end else if (is_flood) begin
        tok_o.base_action = iprt_pkg::ACT_FLOOD;
      end else if (dst_addr == my_addr_i) begin
        tok_o.base_action = iprt_pkg::ACT_UNICAST;
        tok_o.base_port   = local_port_i;
      end else begin
        tok_o.lookup_en   = 1'b1;
        tok_o.base_action = iprt_pkg::ACT_MISS;
      end
    end
  end

endmodule

### src/iprt_cell.sv
// One route table entry that learns from and answers the token passing through it.
module iprt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  iprt_pkg::token_t tok_i,
  output iprt_pkg::token_t tok_o,
  output logic             valid_o
);

  logic                               valid_q;
  logic [iprt_pkg::ADDR_W-1:0]        addr_q;
  logic [iprt_pkg::PORT_W-1:0]        port_q;
  logic [iprt_pkg::PEER_W-1:0]        peer_q;
  logic signed [iprt_pkg::PRIO_W-1:0] prio_q;

  logic                               tok_vld_q;
  iprt_pkg::token_t                   tok_q;
  iprt_pkg::token_t                   tok_d;

  logic                               learn_open;
  logic                               learn_hit;
  logic                               do_rep;
  logic                               do_add;
  logic                               valid_d;
  logic [iprt_pkg::ADDR_W-1:0]        addr_d;
  logic [iprt_pkg::PORT_W-1:0]        port_d;
  logic [iprt_pkg::PEER_W-1:0]        peer_d;
  logic signed [iprt_pkg::PRIO_W-1:0] prio_d;

  assign learn_open = tok_i.learn_en && !tok_i.learn_done;
  assign learn_hit  = learn_open && valid_q && (addr_q == tok_i.learn_addr);
  assign do_rep     = learn_hit && (prio_q <= tok_i.learn_prio);
  assign do_add     = learn_open && !valid_q;

  always_comb begin
    valid_d = valid_q || do_add;
    addr_d  = do_add ? tok_i.learn_addr : addr_q;
    port_d  = (do_add || do_rep) ? tok_i.learn_port : port_q;
    peer_d  = (do_add || do_rep) ? tok_i.learn_peer : peer_q;
    prio_d  = do_add ? '0 : (do_rep ? tok_i.learn_prio : prio_q);

    tok_d = tok_i;
    if (learn_hit || do_add) begin
      tok_d.learn_done = 1'b1;
      if (do_add) begin
        tok_d.ls = iprt_pkg::LS_ADDED;
      end else if (do_rep) begin
        tok_d.ls = iprt_pkg::LS_REPLACED;
      end else begin
        tok_d.ls = iprt_pkg::LS_SAME;
      end
    end
    if (tok_i.lookup_en && !tok_i.hit && valid_d && (addr_d == tok_i.dst_addr)) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_port = port_d;
      tok_d.hit_peer = peer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (en_i) begin
      tok_vld_q <= tok_i.valid;
      if (tok_i.valid) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
      if (tok_i.valid && (do_add || do_rep)) begin
        addr_q <= addr_d;
        port_q <= port_d;
        peer_q <= peer_d;
        prio_q <= prio_d;
      end
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

  assign valid_o = valid_q;

endmodule

### src/ipv4_forwarding_route_table.sv
// Top level of the learning IPv4 route table built as a chain of entry cells.
//
// Items arrive on the s_axis channel: tuser selects a packet header (0) or a
// router advert entry (1), tdata carries the header summary and advert fields.
// Each item yields exactly one result on the m_axis channel: tuser holds the
// action code, tdata the egress port, egress peer, learn status and entry count.
// Registers my_addr and local_port are written over the cfg channel, which is
// always ready; write them only while no item is in flight.
// An accepted item is decoded and enters a chain of TABLE_DEPTH cells, one per
// table entry, advancing one cell per cycle unless the chain holds; each cell
// learns and looks up in passing. The result is then registered at the tail.
// Several items travel the chain at once, so one item is accepted every cycle
// unless the chain holds. When the result register is full and m_axis_tready_i
// is low, the whole chain and the input hold until the result is taken.
// Reset clears all entries, the entry count, both registers and the chain; no
// clearing pass is needed.
module ipv4_forwarding_route_table #(
  parameter int unsigned TABLE_DEPTH = iprt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // version, header_words, ttl, packet_length, src_addr, dst_addr,
  // ingress_port, from_endpoint, advert_addr, advert_prio, zero fill
  input  logic [iprt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // operation
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // egress_port, egress_endpoint, learn_status, entry_total, zero fill
  output logic [iprt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // action
  output logic [2:0]                          m_axis_tuser_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [iprt_pkg::ADDR_W-1:0]    my_addr_q;
  logic [iprt_pkg::PORT_W-1:0]    local_port_q;

  iprt_pkg::token_t               chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]         cell_valid;
  logic                           chain_en;

  iprt_pkg::token_t               tail;
  iprt_pkg::learn_e               tail_ls;
  iprt_pkg::action_e              tail_action;
  logic [iprt_pkg::PORT_W-1:0]    tail_port;
  logic [iprt_pkg::PEER_W-1:0]    tail_peer;
  logic [CNT_W-1:0]               cnt_q;
  logic [CNT_W-1:0]               cnt_d;

  logic                           out_valid_q;
  logic [iprt_pkg::OUT_TDATA_W-1:0] out_tdata_q;
  logic [2:0]                     out_tuser_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q    <= '0;
      local_port_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iprt_pkg::REG_MY_ADDR:    my_addr_q    <= cfg_data_i;
        iprt_pkg::REG_LOCAL_PORT: local_port_q <= cfg_data_i[iprt_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  assign chain_en        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = chain_en;

  iprt_decode u_decode (
    .valid_i      (s_axis_tvalid_i),
    .tdata_i      (s_axis_tdata_i),
    .tuser_i      (s_axis_tuser_i),
    .my_addr_i    (my_addr_q),
    .local_port_i (local_port_q),
    .tok_o        (chain[0])
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    iprt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1]),
      .valid_o (cell_valid[i])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    tail_ls     = (tail.learn_en && !tail.learn_done) ? iprt_pkg::LS_FULL : tail.ls;
    tail_action = tail.base_action;
    tail_port   = tail.base_port;
    tail_peer   = '0;
    if (tail.lookup_en) begin
      if (tail.hit) begin
        tail_action = iprt_pkg::ACT_UNICAST;
        tail_port   = tail.hit_port;
        tail_peer   = tail.hit_peer;
      end else begin
        tail_action = iprt_pkg::ACT_MISS;
      end
    end
    cnt_d = cnt_q + CNT_W'(tail.valid && (tail_ls == iprt_pkg::LS_ADDED));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (chain_en) begin
      out_valid_q <= tail.valid;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_en) begin
      out_tuser_q <= tail_action;
      out_tdata_q <= {5'd0, iprt_pkg::TOTAL_W'(cnt_d), tail_ls, tail_peer, tail_port};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("valid entries do not form a prefix of the chain");

  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && tail_ls == iprt_pkg::LS_FULL) |-> cell_valid[TABLE_DEPTH-1])
    else $error("table full reported with a free entry");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_en && tail.valid && tail_ls == iprt_pkg::LS_FULL) |=>
      cnt_q == CNT_W'(TABLE_DEPTH))
    else $error("table full reported while count below depth");

endmodule
